/* hw/rtl/tpq_pkg.sv */
// tpq_pkg: shared types, constants and helper functions of the tag presence qualifier
// used by tpq_core, tpq_fifo and tag_presence_qualifier; no dependencies
package tpq_pkg;

    // uid store size in bytes and time counter width
    localparam int UID_BYTES  = 7;
    localparam int TIME_BITS  = 32;
    localparam int UID_W      = 56;
    localparam int LEN_W      = 3;
    localparam int CD_W       = 16;
    // largest usable uid length: store size, limited by the uid field capacity
    localparam int UID_CAP    = (UID_BYTES < 7) ? UID_BYTES : 7;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    // register map
    localparam logic [2:0] ADDR_READY    = 3'd0;
    localparam logic [2:0] ADDR_COOLDOWN = 3'd4;
    localparam logic [15:0] COOLDOWN_RST = 16'd1200;

    typedef enum logic [1:0] {
        EV_SCAN     = 2'd0,
        EV_COOLDOWN = 2'd1,
        EV_REMOVED  = 2'd2,
        EV_ARMED    = 2'd3
    } t_event;

    typedef struct packed {
        logic                 cmd;
        logic                 read_ok;
        logic [UID_W-1:0]     uid;
        logic [LEN_W-1:0]     uid_length;
        logic [TIME_BITS-1:0] now_ms;
    } t_item;

    typedef struct packed {
        t_event           event_res;
        logic [UID_W-1:0] tag_uid;
        logic [LEN_W-1:0] tag_uid_length;
        logic             last_of_run;
    } t_result;

    // results raised by one beat, first in slot 0
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    typedef struct packed {
        logic             reader_ready;
        logic [CD_W-1:0]  cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             room;
    } t_fifo_stat;

    // clamp a length to the usable uid size
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] cap;
        cap = LEN_W'(UID_CAP);
        return (len > cap) ? cap : len;
    endfunction

    // mask covering the low n bytes of a uid
    function automatic logic [UID_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [UID_W-1:0] m;
        for (int b = 0; b < UID_W / 8; b++) begin
            m[b*8 +: 8] = (LEN_W'(b) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

/* hw/rtl/tpq_core.sv */
// tpq_core: qualifier state and per-beat event decision
// depends on tpq_pkg
module tpq_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  tpq_pkg::t_item  i_item,
    input  tpq_pkg::t_cfg   i_cfg,
    output tpq_pkg::t_push  o_push
);

    logic                          r_armed;
    logic                          r_tag_present;
    logic [tpq_pkg::UID_W-1:0]     r_last_uid;
    logic [tpq_pkg::LEN_W-1:0]     r_last_count;
    logic [tpq_pkg::TIME_BITS-1:0] r_last_time;

    logic                          n_armed;
    logic                          n_tag_present;
    logic [tpq_pkg::UID_W-1:0]     n_last_uid;
    logic [tpq_pkg::LEN_W-1:0]     n_last_count;
    logic [tpq_pkg::TIME_BITS-1:0] n_last_time;

    logic [tpq_pkg::LEN_W-1:0]     len;
    logic [tpq_pkg::UID_W-1:0]     uid;
    logic [tpq_pkg::TIME_BITS-1:0] elapsed;
    logic                          repeat_hit;
    tpq_pkg::t_result              ev_removed;
    tpq_pkg::t_result              ev_armed;
    tpq_pkg::t_result              ev_tag;

    // masked uid, elapsed time and repeat test
    assign len     = tpq_pkg::eff_len(i_item.uid_length);
    assign uid     = i_item.uid & tpq_pkg::byte_mask(len);
    assign elapsed = i_item.now_ms - r_last_time;
    assign repeat_hit = (r_last_time != '0)
        && (elapsed < tpq_pkg::TIME_BITS'(i_cfg.cooldown_ms))
        && (len == r_last_count)
        && (uid == (r_last_uid & tpq_pkg::byte_mask(r_last_count)));

    // next state and results of the current beat
    always_comb begin
        n_armed       = r_armed;
        n_tag_present = r_tag_present;
        n_last_uid    = r_last_uid;
        n_last_count  = r_last_count;
        n_last_time   = r_last_time;

        ev_removed = '{event_res: tpq_pkg::EV_REMOVED, tag_uid: '0,
                       tag_uid_length: '0, last_of_run: !(!r_armed)};
        ev_armed   = '{event_res: tpq_pkg::EV_ARMED, tag_uid: '0,
                       tag_uid_length: '0, last_of_run: 1'b1};
        ev_tag     = '{event_res: repeat_hit ? tpq_pkg::EV_COOLDOWN : tpq_pkg::EV_SCAN,
                       tag_uid: uid, tag_uid_length: len, last_of_run: 1'b1};

        o_push = '{num: 2'd0, res0: ev_tag, res1: ev_armed};

        if (i_item.cmd) begin
            n_armed       = 1'b0;
            n_tag_present = 1'b0;
            n_last_count  = '0;
            n_last_time   = '0;
        end else if (i_cfg.reader_ready) begin
            if (!i_item.read_ok) begin
                // tag left, then arm
                n_tag_present = 1'b0;
                n_armed       = 1'b1;
                if (r_tag_present && !r_armed) begin
                    o_push.num  = 2'd2;
                    o_push.res0 = ev_removed;
                    o_push.res1 = ev_armed;
                end else if (r_tag_present) begin
                    o_push.num  = 2'd1;
                    o_push.res0 = ev_removed;
                end else if (!r_armed) begin
                    o_push.num  = 2'd1;
                    o_push.res0 = ev_armed;
                end
            end else if (r_armed && !r_tag_present) begin
                n_tag_present = 1'b1;
                o_push.num    = 2'd1;
                o_push.res0   = ev_tag;
                if (!repeat_hit) begin
                    n_last_uid   = uid;
                    n_last_count = len;
                    n_last_time  = i_item.now_ms;
                end
            end
        end

        if (!i_accept) begin
            o_push.num = 2'd0;
        end
    end

    // qualifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed       <= 1'b0;
            r_tag_present <= 1'b0;
            r_last_uid    <= '0;
            r_last_count  <= '0;
            r_last_time   <= '0;
        end else if (i_accept) begin
            r_armed       <= n_armed;
            r_tag_present <= n_tag_present;
            r_last_uid    <= n_last_uid;
            r_last_count  <= n_last_count;
            r_last_time   <= n_last_time;
        end
    end

endmodule

/* hw/rtl/tpq_fifo.sv */
// tpq_fifo: four-entry result queue taking up to two results per beat
// depends on tpq_pkg
module tpq_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tpq_pkg::t_push       i_push,
    input  logic                 i_pop,
    output tpq_pkg::t_result     o_head,
    output logic                 o_valid,
    output tpq_pkg::t_fifo_stat  o_stat
);

    tpq_pkg::t_result              r_mem [tpq_pkg::FIFO_DEPTH];
    logic [tpq_pkg::PTR_W-1:0]     r_wr_ptr;
    logic [tpq_pkg::PTR_W-1:0]     r_rd_ptr;
    logic [tpq_pkg::CNT_W-1:0]     r_count;
    logic [tpq_pkg::PTR_W-1:0]     wr_next;
    logic                          pop_ok;

    assign wr_next = r_wr_ptr + tpq_pkg::PTR_W'(1);
    assign pop_ok  = i_pop && (r_count != '0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + tpq_pkg::PTR_W'(i_push.num);
            r_rd_ptr <= r_rd_ptr + tpq_pkg::PTR_W'(pop_ok);
            r_count  <= r_count + tpq_pkg::CNT_W'(i_push.num)
                        - tpq_pkg::CNT_W'(pop_ok);
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_valid      = (r_count != '0);
    assign o_stat.count = r_count;
    // room for a beat raising two results
    assign o_stat.room  = (r_count <= tpq_pkg::CNT_W'(tpq_pkg::FIFO_DEPTH - 2));

endmodule

/* hw/rtl/tag_presence_qualifier.sv */
// tag_presence_qualifier: top level with config registers, qualifier core and result queue
// depends on tpq_pkg, tpq_core, tpq_fifo
//
// Usage:
//  - slave stream carries poll results and clear commands; tuser is the command
//    (0 poll, 1 clear), tdata the poll payload
//  - master stream carries events: tuser is the event code, tlast marks the last
//    event raised by one input beat, tdata the uid and its byte count
//  - apb port holds reader_ready (0x0) and cooldown_ms (0x4); pready is always high
//  - an input beat is decided in the cycle it is accepted; its events enter a
//    four-entry queue and appear on the master side from the registered queue head
//  - throughput is one input beat per cycle while s_tready is high; a beat
//    yields at most two events, each sent as its own output beat
//  - s_tready stays high while the queue has room for two events, so a stall
//    on the master side fills the queue and then holds the slave side
//  - synchronous reset empties the queue, clears all qualifier state and sets
//    reader_ready to 0 and cooldown_ms to 1200
module tag_presence_qualifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // read_ok[0], uid[56:1], uid_length[59:57], now_ms[91:60]
    input  logic [0:0]  s_tuser,   // cmd[0]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // tag_uid[55:0], tag_uid_length[58:56]
    output logic [1:0]  m_tuser,   // event_res[1:0]
    output logic        m_tlast,   // last_of_run
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                r_reader_ready;
    logic [15:0]         r_cooldown_ms;
    tpq_pkg::t_cfg       cfg;
    tpq_pkg::t_item      item;
    tpq_pkg::t_push      push;
    tpq_pkg::t_result    head;
    tpq_pkg::t_fifo_stat stat;
    logic                s_accept;
    logic                cfg_wr;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reader_ready <= 1'b0;
            r_cooldown_ms  <= tpq_pkg::COOLDOWN_RST;
        end else if (cfg_wr) begin
            case (paddr)
                tpq_pkg::ADDR_READY:    r_reader_ready <= pwdata[0];
                tpq_pkg::ADDR_COOLDOWN: r_cooldown_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            tpq_pkg::ADDR_READY:    prdata = {31'd0, r_reader_ready};
            tpq_pkg::ADDR_COOLDOWN: prdata = {16'd0, r_cooldown_ms};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.reader_ready = r_reader_ready;
    assign cfg.cooldown_ms  = r_cooldown_ms;

    // input beat unpacking
    assign s_tready        = stat.room;
    assign s_accept        = s_tvalid && s_tready;
    assign item.cmd        = s_tuser[0];
    assign item.read_ok    = s_tdata[0];
    assign item.uid        = s_tdata[56:1];
    assign item.uid_length = s_tdata[59:57];
    assign item.now_ms     = s_tdata[91:60];

    tpq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_push   (push)
    );

    tpq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_tready),
        .o_head  (head),
        .o_valid (m_tvalid),
        .o_stat  (stat)
    );

    // output beat packing
    assign m_tdata = {5'd0, head.tag_uid_length, head.tag_uid};
    assign m_tuser = head.event_res;
    assign m_tlast = head.last_of_run;

`ifndef ASSERT_OFF
    // queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= 3'(tpq_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // a clear command raises no event
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_tuser[0]) |=> (stat.count <= $past(stat.count)))
        else $error("clear command raised an event");

    // an offline reader raises no event
    a_offline_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !r_reader_ready) |=> (stat.count <= $past(stat.count)))
        else $error("event raised while reader offline");
`endif

endmodule
